// ----- design/tpcd_pkg.sv -----
// Shared types and constants of the triangle coverage and depth test block.
package tpcd_pkg;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_PIXEL = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] VIDX_FIRST = 2'd0;
	localparam logic [1:0] VIDX_BAD   = 2'd3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [9:0] RESET_SIZE = 10'd512;

	localparam int ONE_Q14     = 16384;
	localparam int WEIGHT_BITS = 15;

	typedef enum logic [3:0] {
		MUL_NONE, MUL_MX, MUL_MY,
		MUL_E0A, MUL_E0B, MUL_E1A, MUL_E1B, MUL_E2A, MUL_E2B,
		MUL_ZA, MUL_ZB, MUL_ZC, MUL_WA, MUL_WB, MUL_WC, MUL_ZW
	} mul_sel_t;

	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

	typedef enum logic [2:0] {ST_NONE, ST_SX, ST_SY, ST_E0, ST_E1, ST_E2, ST_ZS, ST_WS} st_sel_t;

	typedef struct packed {
		logic     latch;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		st_sel_t  st_sel;
		logic     ld_meta;
		logic     area_ld;
		logic     div_start;
		logic     div_sel;
		logic     d_ld;
		logic     ram_rd;
		logic     ram_upd;
		logic     clr_step;
		logic     out_ld;
		logic     out_zero;
	} cmd_t;

	typedef struct packed {
		logic early_out;
		logic covered;
		logic div_busy;
		logic div_done;
		logic clr_last;
	} status_t;

endpackage

// ----- design/tpcd_ram.sv -----
// Generic single write port RAM with one registered read port.
module tpcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/tpcd_div.sv -----
// Restoring divider giving the fractional weight quotient one bit per cycle.
module tpcd_div
	import tpcd_pkg::*;
#(
	parameter int NW = 40
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NW-1:0]          num,
	input  logic [NW-1:0]          den,
	output logic [WEIGHT_BITS-1:0] quot,
	output logic                   busy,
	output logic                   done
);

	logic [NW:0]            rem_q;
	logic [NW-1:0]          den_q;
	logic [WEIGHT_BITS-1:0] quot_q;
	logic [3:0]             cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [NW:0]            rem2;
	logic                   ge;

	// numerator is below the divisor, so the remainder always fits NW bits
	assign rem2 = {rem_q[NW-1:0], 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (rem2 - {1'b0, den_q}) : rem2;
			quot_q <= {quot_q[WEIGHT_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(WEIGHT_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot = quot_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ----- design/tpcd_datapath.sv -----
// Datapath: vertex store, shared multiplier and accumulator, divider and depth store.
module tpcd_datapath
	import tpcd_pkg::*;
#(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT,
	localparam int SZW  = $clog2(MAXD + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [1:0]         vertex_index,
	input  logic signed [15:0] ndc_x,
	input  logic signed [15:0] ndc_y,
	input  logic signed [15:0] ndc_z,
	input  logic signed [31:0] clip_w,
	input  logic [8:0]         pixel_x,
	input  logic [8:0]         pixel_y,
	input  logic [SZW-1:0]     wv,
	input  logic [SZW-1:0]     hv,
	output logic               covered,
	output logic               depth_passed,
	output logic signed [31:0] frag_depth,
	output logic signed [31:0] frag_w,
	output logic [15:0]        weight_a,
	output logic [15:0]        weight_b,
	output logic [15:0]        weight_c
);

	localparam int CW0   = $clog2(MAXD) + 5;
	localparam int CW    = (CW0 > 14) ? CW0 : 14;
	localparam int DW    = CW + 1;
	localparam int EW    = 2 * DW + 1;
	localparam int NW    = EW + 2;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [15:0] map_in(input logic signed [15:0] c);
		logic signed [16:0] cc;
		cc = 17'(c);
		if (c < -ONE_Q14) cc = -17'sd16384;
		if (c > ONE_Q14) cc = 17'sd16384;
		return 16'(cc + 17'sd16384);
	endfunction

	function automatic logic off_range(input logic signed [15:0] c);
		return (c < -ONE_Q14) || (c > ONE_Q14);
	endfunction

	function automatic logic signed [DW-1:0] diff(input logic [CW-1:0] b, input logic [CW-1:0] a);
		return $signed({1'b0, b}) - $signed({1'b0, a});
	endfunction

	function automatic logic [31:0] sx32(input logic signed [DW-1:0] d);
		return {{(32-DW){d[DW-1]}}, d};
	endfunction

	function automatic logic [EW-1:0] mag_e(input logic signed [EW-1:0] e);
		return e[EW-1] ? EW'(-e) : EW'(e);
	endfunction

	// latched item
	logic [1:0]         vidx_q;
	logic signed [15:0] nx_q, ny_q, nz_q;
	logic signed [31:0] w_q;
	logic [8:0]         px_q, py_q;

	// triangle state
	logic [CW-1:0]      sx_q [3];
	logic [CW-1:0]      sy_q [3];
	logic signed [15:0] vz_q [3];
	logic signed [31:0] vw_q [3];
	logic               rej_q;

	logic signed [31:0]   op_a, op_b;
	logic signed [63:0]   mul_w;
	logic signed [63:0]   prod_q;
	logic signed [63:0]   acc_q;
	logic signed [EW-1:0] e0_q, e1_q, e2_q;
	logic [NW-1:0]        area_q;
	logic signed [EW+1:0] esum;
	logic signed [31:0]   zs_q, fw_q, d_q;
	logic signed [34:0]   dd;
	logic [WEIGHT_BITS-1:0] a_q, b_q, quot;
	logic [16:0]          c_w;
	logic                 div_sel_q, div_busy, div_done;
	logic [NW-1:0]        div_num;
	logic                 pass_q, pass_w;
	logic [31:0]          mag, rdata, wdata;
	logic [AW-1:0]        clr_addr_q, pos, waddr;
	logic                 clr_last, we;
	logic [CW-1:0]        cx, cy;
	logic                 bad;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			vidx_q <= vertex_index;
			nx_q   <= ndc_x;
			ny_q   <= ndc_y;
			nz_q   <= ndc_z;
			w_q    <= clip_w;
			px_q   <= pixel_x;
			py_q   <= pixel_y;
		end
	end

	assign bad = off_range(nx_q) | off_range(ny_q) | off_range(nz_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				sx_q[i] <= '0;
				sy_q[i] <= '0;
				vz_q[i] <= '0;
				vw_q[i] <= '0;
			end
			rej_q <= 1'b1;
		end else begin
			if (cmd.ld_meta) begin
				vz_q[vidx_q] <= nz_q;
				vw_q[vidx_q] <= w_q;
				rej_q        <= (vidx_q == VIDX_FIRST) ? bad : (rej_q | bad);
			end
			if (cmd.st_sel == ST_SX) sx_q[vidx_q] <= prod_q[CW+10:11];
			if (cmd.st_sel == ST_SY) sy_q[vidx_q] <= prod_q[CW+10:11];
		end
	end

	assign cx = {{(CW-13){1'b0}}, px_q, 4'b1000};
	assign cy = {{(CW-13){1'b0}}, py_q, 4'b1000};
	assign c_w = 17'd32768 - {2'b00, a_q} - {2'b00, b_q};

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_sel)
			MUL_MX: begin
				op_a = {16'd0, map_in(nx_q)};
				op_b = 32'(wv);
			end
			MUL_MY: begin
				op_a = {16'd0, map_in(ny_q)};
				op_b = 32'(hv);
			end
			MUL_E0A: begin
				op_a = sx32(diff(sx_q[1], sx_q[0]));
				op_b = sx32(diff(cy, sy_q[0]));
			end
			MUL_E0B: begin
				op_a = sx32(diff(sy_q[1], sy_q[0]));
				op_b = sx32(diff(cx, sx_q[0]));
			end
			MUL_E1A: begin
				op_a = sx32(diff(sx_q[2], sx_q[1]));
				op_b = sx32(diff(cy, sy_q[1]));
			end
			MUL_E1B: begin
				op_a = sx32(diff(sy_q[2], sy_q[1]));
				op_b = sx32(diff(cx, sx_q[1]));
			end
			MUL_E2A: begin
				op_a = sx32(diff(sx_q[0], sx_q[2]));
				op_b = sx32(diff(cy, sy_q[2]));
			end
			MUL_E2B: begin
				op_a = sx32(diff(sy_q[0], sy_q[2]));
				op_b = sx32(diff(cx, sx_q[2]));
			end
			MUL_ZA: begin
				op_a = 32'(vz_q[0]);
				op_b = 32'(a_q);
			end
			MUL_ZB: begin
				op_a = 32'(vz_q[1]);
				op_b = 32'(b_q);
			end
			MUL_ZC: begin
				op_a = 32'(vz_q[2]);
				op_b = 32'(c_w);
			end
			MUL_WA: begin
				op_a = vw_q[0];
				op_b = 32'(a_q);
			end
			MUL_WB: begin
				op_a = vw_q[1];
				op_b = 32'(b_q);
			end
			MUL_WC: begin
				op_a = vw_q[2];
				op_b = 32'(c_w);
			end
			MUL_ZW: begin
				op_a = zs_q;
				op_b = fw_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_w = op_a * op_b;
	assign esum  = (EW+2)'(e0_q) + (EW+2)'(e1_q) + (EW+2)'(e2_q);
	assign dd    = prod_q[63:29];

	always_ff @(posedge clk) begin
		prod_q <= mul_w;
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= prod_q;
			ACC_ADD:  acc_q <= acc_q + prod_q;
			ACC_SUB:  acc_q <= acc_q - prod_q;
			default:  acc_q <= acc_q;
		endcase
		case (cmd.st_sel)
			ST_E0:   e0_q <= acc_q[EW-1:0];
			ST_E1:   e1_q <= acc_q[EW-1:0];
			ST_E2:   e2_q <= acc_q[EW-1:0];
			ST_ZS:   zs_q <= acc_q[31:0];
			ST_WS:   fw_q <= acc_q[46:15];
			default: ;
		endcase
		if (cmd.area_ld) begin
			area_q <= esum[EW+1] ? NW'(-esum) : NW'(esum);
		end
		if (cmd.div_start) begin
			div_sel_q <= cmd.div_sel;
		end
		if (div_done) begin
			if (div_sel_q) b_q <= quot;
			else a_q <= quot;
		end
		if (cmd.d_ld) begin
			// saturate the Q16.16 depth to 32 bits
			if (dd[34:31] != {4{dd[34]}}) d_q <= dd[34] ? 32'sh80000000 : 32'sh7fffffff;
			else d_q <= dd[31:0];
		end
		if (cmd.ram_upd) begin
			pass_q <= pass_w;
		end
	end

	assign div_num = cmd.div_sel ? NW'(mag_e(e2_q)) : NW'(mag_e(e1_q));

	tpcd_div #(.NW(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (area_q),
		.quot   (quot),
		.busy   (div_busy),
		.done   (div_done)
	);

	// depth store
	assign mag    = d_q[31] ? 32'(-d_q) : 32'(d_q);
	assign pass_w = mag < rdata;
	assign pos    = AW'(int'(py_q) * MAX_WIDTH + int'(px_q));
	assign clr_last = clr_addr_q == AW'(DEPTH - 1);
	assign we     = cmd.clr_step | (cmd.ram_upd & pass_w);
	assign waddr  = cmd.clr_step ? clr_addr_q : pos;
	assign wdata  = cmd.clr_step ? '1 : mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
		end
	end

	tpcd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_depth (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.ram_rd),
		.raddr (pos),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			if (cmd.out_zero) begin
				covered      <= 1'b0;
				depth_passed <= 1'b0;
				frag_depth   <= '0;
				frag_w       <= '0;
				weight_a     <= '0;
				weight_b     <= '0;
				weight_c     <= '0;
			end else begin
				covered      <= 1'b1;
				depth_passed <= pass_q;
				frag_depth   <= d_q;
				frag_w       <= fw_q;
				weight_a     <= {1'b0, a_q};
				weight_b     <= {1'b0, b_q};
				weight_c     <= c_w[15:0];
			end
		end
	end

	always_comb begin
		status.early_out = rej_q | (int'(px_q) >= int'(wv)) | (int'(py_q) >= int'(hv));
		status.covered   = ((e0_q > 0) && (e1_q > 0) && (e2_q > 0)) ||
		                   ((e0_q < 0) && (e1_q < 0) && (e2_q < 0));
		status.div_busy  = div_busy;
		status.div_done  = div_done;
		status.clr_last  = clr_last;
	end

endmodule

// ----- design/tpcd_ctrl.sv -----
// Controller: sequences loads, pixel tests, depth store clears and result transfers.
module tpcd_ctrl
	import tpcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] func,
	input  logic [1:0] vertex_index,
	output logic       result_valid,
	input  logic       result_ready,
	input  status_t    status,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOAD, S_PIX, S_EDGE, S_DIVA, S_DIVB, S_INTERP, S_DONE
	} state_t;

	localparam logic [3:0] LOAD_LAST   = 4'd2;
	localparam logic [3:0] EDGE_LAST   = 4'd9;
	localparam logic [3:0] INTERP_LAST = 4'd10;

	state_t     state_q;
	logic [3:0] step_q;
	logic       zero_q;
	logic       clr_res_q;
	logic       out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE:  cmd.latch = item_valid;
			S_LOAD: begin
				case (step_q)
					4'd0: begin
						cmd.mul_sel = MUL_MX;
						cmd.ld_meta = 1'b1;
					end
					4'd1: begin
						cmd.mul_sel = MUL_MY;
						cmd.st_sel  = ST_SX;
					end
					4'd2:    cmd.st_sel = ST_SY;
					default: ;
				endcase
			end
			S_EDGE: begin
				// products land in the cycle after issue and fold into the accumulator
				case (step_q)
					4'd0: cmd.mul_sel = MUL_E0A;
					4'd1: begin
						cmd.mul_sel = MUL_E0B;
						cmd.acc_op  = ACC_LOAD;
					end
					4'd2: begin
						cmd.mul_sel = MUL_E1A;
						cmd.acc_op  = ACC_SUB;
					end
					4'd3: begin
						cmd.mul_sel = MUL_E1B;
						cmd.acc_op  = ACC_LOAD;
						cmd.st_sel  = ST_E0;
					end
					4'd4: begin
						cmd.mul_sel = MUL_E2A;
						cmd.acc_op  = ACC_SUB;
					end
					4'd5: begin
						cmd.mul_sel = MUL_E2B;
						cmd.acc_op  = ACC_LOAD;
						cmd.st_sel  = ST_E1;
					end
					4'd6: cmd.acc_op = ACC_SUB;
					4'd7: cmd.st_sel = ST_E2;
					4'd8: cmd.area_ld = 1'b1;
					4'd9: cmd.div_start = status.covered;
					default: ;
				endcase
			end
			S_DIVA: begin
				cmd.div_start = status.div_done;
				cmd.div_sel   = 1'b1;
			end
			S_INTERP: begin
				case (step_q)
					4'd0: begin
						cmd.mul_sel = MUL_ZA;
						cmd.ram_rd  = 1'b1;
					end
					4'd1: begin
						cmd.mul_sel = MUL_ZB;
						cmd.acc_op  = ACC_LOAD;
					end
					4'd2: begin
						cmd.mul_sel = MUL_ZC;
						cmd.acc_op  = ACC_ADD;
					end
					4'd3: begin
						cmd.mul_sel = MUL_WA;
						cmd.acc_op  = ACC_ADD;
					end
					4'd4: begin
						cmd.mul_sel = MUL_WB;
						cmd.acc_op  = ACC_LOAD;
						cmd.st_sel  = ST_ZS;
					end
					4'd5: begin
						cmd.mul_sel = MUL_WC;
						cmd.acc_op  = ACC_ADD;
					end
					4'd6:    cmd.acc_op = ACC_ADD;
					4'd7:    cmd.st_sel = ST_WS;
					4'd8:    cmd.mul_sel = MUL_ZW;
					4'd9:    cmd.d_ld = 1'b1;
					4'd10:   cmd.ram_upd = 1'b1;
					default: ;
				endcase
			end
			S_DONE: begin
				cmd.out_ld   = !out_valid_q || result_ready;
				cmd.out_zero = zero_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			step_q      <= '0;
			zero_q      <= 1'b1;
			clr_res_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;

			case (state_q)
				S_CLEAR: begin
					if (status.clr_last) begin
						state_q <= clr_res_q ? S_DONE : S_IDLE;
						zero_q  <= 1'b1;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						step_q <= '0;
						zero_q <= 1'b1;
						case (func)
							FUNC_LOAD:  state_q <= (vertex_index == VIDX_BAD) ? S_DONE : S_LOAD;
							FUNC_PIXEL: state_q <= S_PIX;
							FUNC_CLEAR: begin
								state_q   <= S_CLEAR;
								clr_res_q <= 1'b1;
							end
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_LOAD: begin
					step_q <= step_q + 4'd1;
					if (step_q == LOAD_LAST) state_q <= S_DONE;
				end
				S_PIX: begin
					step_q  <= '0;
					state_q <= status.early_out ? S_DONE : S_EDGE;
				end
				S_EDGE: begin
					step_q <= step_q + 4'd1;
					if (step_q == EDGE_LAST) begin
						if (status.covered) begin
							state_q <= S_DIVA;
							zero_q  <= 1'b0;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DIVA: begin
					if (status.div_done) state_q <= S_DIVB;
				end
				S_DIVB: begin
					if (status.div_done) begin
						state_q <= S_INTERP;
						step_q  <= '0;
					end
				end
				S_INTERP: begin
					step_q <= step_q + 4'd1;
					if (step_q == INTERP_LAST) state_q <= S_DONE;
				end
				S_DONE: begin
					if (cmd.out_ld) begin
						state_q   <= S_IDLE;
						clr_res_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item_ready   = state_q == S_IDLE;
	assign result_valid = out_valid_q;

	a_upd_after_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ram_upd |-> $past(cmd.d_ld))
		else $error("depth store update without a captured depth");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.div_busy)
		else $error("divider restarted while busy");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clr_step && status.clr_last) |=> !cmd.clr_step)
		else $error("clearing sweep ran past the last entry");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.latch && item_ready) |=> !item_ready)
		else $error("transfer accepted while an item is in flight");

endmodule

// ----- design/triangle_pixel_coverage_depth_test.sv -----
// Top level: APB register file, controller and datapath of the coverage and depth test.
//
// Items arrive on the item channel (item_valid/item_ready) and each gives exactly one
// result on the result channel (result_valid/result_ready). func selects a vertex load,
// a pixel test or a depth store clear; loads, clears, no-ops and uncovered pixels return zeros.
// One item is worked on at a time; the result sits in an output register, so the next
// item is taken while a finished result still waits for its transfer.
// The edge, weight and depth products all go through one shared 32x32 multiplier, and
// the two weights come from a divider that yields one bit per cycle. A clear walks the
// depth store one entry per cycle. After reset the same clearing pass runs first and no
// item is taken until it ends; register writes are taken throughout.
// When the receiver stalls, the held result stays put and the block stops after finishing
// the next item. screen_width and screen_height are written over the APB port at 0 and 4.
module triangle_pixel_coverage_depth_test
	import tpcd_pkg::*;
#(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         func,
	input  logic [1:0]         vertex_index,
	input  logic signed [15:0] ndc_x,
	input  logic signed [15:0] ndc_y,
	input  logic signed [15:0] ndc_z,
	input  logic signed [31:0] clip_w,
	input  logic [8:0]         pixel_x,
	input  logic [8:0]         pixel_y,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               covered,
	output logic               depth_passed,
	output logic signed [31:0] frag_depth,
	output logic signed [31:0] frag_w,
	output logic [15:0]        weight_a,
	output logic [15:0]        weight_b,
	output logic [15:0]        weight_c
);

	localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int SZW  = $clog2(MAXD + 1);

	logic [9:0]     width_q, height_q;
	logic [SZW-1:0] wv, hv;
	cmd_t           cmd;
	status_t        status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_SIZE;
			height_q <= RESET_SIZE;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_WIDTH) width_q <= pwdata[9:0];
			else height_q <= pwdata[9:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {22'd0, height_q} : {22'd0, width_q};

	// zero acts as one, anything above the maximum as the maximum
	always_comb begin
		if (width_q == '0) wv = SZW'(1);
		else if (int'(width_q) > MAX_WIDTH) wv = SZW'(MAX_WIDTH);
		else wv = SZW'(width_q);
		if (height_q == '0) hv = SZW'(1);
		else if (int'(height_q) > MAX_HEIGHT) hv = SZW'(MAX_HEIGHT);
		else hv = SZW'(height_q);
	end

	tpcd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.func         (func),
		.vertex_index (vertex_index),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	tpcd_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.vertex_index (vertex_index),
		.ndc_x        (ndc_x),
		.ndc_y        (ndc_y),
		.ndc_z        (ndc_z),
		.clip_w       (clip_w),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.wv           (wv),
		.hv           (hv),
		.covered      (covered),
		.depth_passed (depth_passed),
		.frag_depth   (frag_depth),
		.frag_w       (frag_w),
		.weight_a     (weight_a),
		.weight_b     (weight_b),
		.weight_c     (weight_c)
	);

endmodule
